[design/assert_macros.svh]
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A property that must hold on every clock edge outside reset.
`define ASSERT_AT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_AT(name, clk, rst, prop)
`define ASSERT_IMPL(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

[design/tmi_pkg.sv]
// Package with sizes, command characters and codes of the tape machine interpreter.
`default_nettype none

package tmi_pkg;

   localparam int PROG_DEPTH = 4096;
   localparam int TAPE_DEPTH = 1024;

   localparam int PC_W       = $clog2(PROG_DEPTH);
   localparam int PC_CNT_W   = PC_W + 1;
   localparam int TAPE_AW    = $clog2(TAPE_DEPTH);
   localparam int TAPE_CNT_W = TAPE_AW + 1;

   localparam int FUNC_W     = 2;
   localparam int ADDR_W     = 12;
   localparam int CHAR_W     = 8;
   localparam int BYTE_W     = 8;
   localparam int CFG_W      = 11;
   localparam int ERR_W      = 2;
   localparam int PCO_W      = 12;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 24;

   localparam logic [CHAR_W-1:0] CH_END   = 8'h00;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
   localparam logic [CHAR_W-1:0] CH_RIGHT = 8'h3E;
   localparam logic [CHAR_W-1:0] CH_LEFT  = 8'h3C;
   localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h5B;
   localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h5D;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD    = 2'd0,
      FUNC_RESTART = 2'd1,
      FUNC_EXEC    = 2'd2
   } func_type;

   typedef enum logic [ERR_W-1:0] {
      FAULT_NONE    = 2'd0,
      FAULT_ABOVE   = 2'd1,
      FAULT_BELOW   = 2'd2,
      FAULT_BRACKET = 2'd3
   } fault_type;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_FETCH   = 4'b0010,
      ST_SCAN    = 4'b0100,
      ST_PUBLISH = 4'b1000
   } state_type;

endpackage

`default_nettype wire

[design/tape_machine_interpreter.sv]
// Load, restart and halted execute pass from IDLE to PUBLISH; execute passes IDLE, FETCH, PUBLISH.
// A bracket scan adds a SCAN state that walks program characters on the program store read port.
// The next item is taken back in IDLE, once PUBLISH has loaded its predecessor into the output register;
// PUBLISH waits while the held response has not been taken.
// Reset clears control state; the tape reads as zero through a fill count,
// with no clearing pass, and the program store is undefined until loaded.
`default_nettype none
`include "assert_macros.svh"

module tape_machine_interpreter
   import tmi_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [CFG_W-1:0]      csr_wr_data,      // tape_size
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,        // program_addr, program_char, input_byte
   input  wire logic [FUNC_W-1:0]     req_tuser,        // func
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,        // out_byte, input_taken, halted,
                                                        // error_code, program_counter
   output logic                       rsp_tuser         // out_valid
);

   state_type             state_ff, state_in;
   logic [PC_W-1:0]       pc_ff, pc_in;
   logic [TAPE_AW-1:0]    ptr_ff, ptr_in;
   logic [TAPE_CNT_W-1:0] fill_ff, fill_in;
   logic [TAPE_CNT_W-1:0] usable_ff, usable_in;
   logic                  halt_ff, halt_in;
   fault_type             fault_ff, fault_in;
   logic [BYTE_W-1:0]     in_byte_ff, in_byte_in;
   logic [PC_W-1:0]       idx_ff, idx_in;
   logic [PC_CNT_W-1:0]   depth_ff, depth_in;
   logic                  back_ff, back_in;
   logic [BYTE_W-1:0]     emit_byte_ff, emit_byte_in;
   logic                  emit_valid_ff, emit_valid_in;
   logic                  taken_ff, taken_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_user_ff, rsp_user_in;

   logic [ADDR_W-1:0]     req_addr;
   logic [CHAR_W-1:0]     req_char;
   logic [BYTE_W-1:0]     req_byte;
   func_type              req_func;
   logic                  req_xfer;

   logic                  prog_we;
   logic [PC_W-1:0]       prog_rd_addr;
   logic [CHAR_W-1:0]     prog_rd_data;
   logic                  tape_we;
   logic [BYTE_W-1:0]     tape_wdata;
   logic [BYTE_W-1:0]     tape_rd_data;

   logic [BYTE_W-1:0]     cell_val;
   logic [TAPE_CNT_W-1:0] ptr_ext;

   // Shared index unit: one incrementer/decrementer serves pc advance and bracket scans.
   logic [PC_W-1:0]       step_base;
   logic                  step_down;
   logic [PC_CNT_W-1:0]   step_sum;
   logic [PC_W-1:0]       step_res;
   logic                  step_over;

   logic                  do_advance;
   logic                  scan_match;

   logic                  exec_go;
   logic                  rsp_stall;

   assign req_addr = req_tdata[ADDR_W-1:0];
   assign req_char = req_tdata[ADDR_W +: CHAR_W];
   assign req_byte = req_tdata[ADDR_W + CHAR_W +: BYTE_W];
   assign req_func = func_type'(req_tuser);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   assign exec_go   = req_xfer && (req_func == FUNC_EXEC) && !halt_ff;
   assign rsp_stall = rsp_valid_ff && !rsp_tready;

   assign ptr_ext  = {1'b0, ptr_ff};
   // Cells at or beyond the fill count were never written since the last clear.
   assign cell_val = (ptr_ext < fill_ff) ? tape_rd_data : '0;

   assign scan_match = (depth_ff == PC_CNT_W'(1)) &&
                       (prog_rd_data == (back_ff ? CH_OPEN : CH_CLOSE));

   always_comb begin
      step_base = (state_ff == ST_SCAN) ? idx_ff : pc_ff;
      step_down = 1'b0;
      if (state_ff == ST_FETCH) begin
         step_down = (prog_rd_data == CH_CLOSE) && (cell_val != '0);
      end else if (state_ff == ST_SCAN) begin
         step_down = back_ff && !scan_match;
      end
      step_sum  = step_down ? ({1'b0, step_base} - PC_CNT_W'(1))
                            : ({1'b0, step_base} + PC_CNT_W'(1));
      step_res  = step_sum[PC_W-1:0];
      step_over = (step_sum >= PC_CNT_W'(PROG_DEPTH));
   end

   always_comb begin
      if (32'(csr_wr_data) == 32'd0) begin
         usable_in = TAPE_CNT_W'(1);
      end else if (32'(csr_wr_data) > 32'(TAPE_DEPTH)) begin
         usable_in = TAPE_CNT_W'(TAPE_DEPTH);
      end else begin
         usable_in = TAPE_CNT_W'(csr_wr_data);
      end
   end

   always_comb begin
      state_in      = state_ff;
      pc_in         = pc_ff;
      ptr_in        = ptr_ff;
      fill_in       = fill_ff;
      halt_in       = halt_ff;
      fault_in      = fault_ff;
      in_byte_in    = in_byte_ff;
      idx_in        = idx_ff;
      depth_in      = depth_ff;
      back_in       = back_ff;
      emit_byte_in  = emit_byte_ff;
      emit_valid_in = emit_valid_ff;
      taken_in      = taken_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      prog_we       = 1'b0;
      prog_rd_addr  = pc_ff;
      tape_we       = 1'b0;
      tape_wdata    = cell_val;
      do_advance    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               emit_byte_in  = '0;
               emit_valid_in = 1'b0;
               taken_in      = 1'b0;
               in_byte_in    = req_byte;
               state_in      = ST_PUBLISH;
               case (req_func)
                  FUNC_LOAD: begin
                     prog_we = (32'(req_addr) < 32'(PROG_DEPTH));
                  end
                  FUNC_RESTART: begin
                     pc_in    = '0;
                     ptr_in   = '0;
                     fill_in  = '0;
                     halt_in  = 1'b0;
                     fault_in = FAULT_NONE;
                  end
                  FUNC_EXEC: begin
                     if (!halt_ff) begin
                        state_in = ST_FETCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_FETCH: begin
            state_in = ST_PUBLISH;
            tape_we  = 1'b1;
            if (ptr_ext == fill_ff) begin
               fill_in = fill_ff + TAPE_CNT_W'(1);
            end
            case (prog_rd_data)
               CH_END: begin
                  halt_in  = 1'b1;
                  fault_in = FAULT_NONE;
               end
               CH_PLUS: begin
                  tape_wdata = cell_val + BYTE_W'(1);
                  do_advance = 1'b1;
               end
               CH_MINUS: begin
                  tape_wdata = cell_val - BYTE_W'(1);
                  do_advance = 1'b1;
               end
               CH_DOT: begin
                  emit_byte_in  = cell_val;
                  emit_valid_in = 1'b1;
                  do_advance    = 1'b1;
               end
               CH_COMMA: begin
                  tape_wdata = in_byte_ff;
                  taken_in   = 1'b1;
                  do_advance = 1'b1;
               end
               CH_RIGHT: begin
                  if ((ptr_ext + TAPE_CNT_W'(1)) >= usable_ff) begin
                     halt_in  = 1'b1;
                     fault_in = FAULT_ABOVE;
                  end else begin
                     ptr_in     = ptr_ff + TAPE_AW'(1);
                     do_advance = 1'b1;
                  end
               end
               CH_LEFT: begin
                  if (ptr_ff == '0) begin
                     halt_in  = 1'b1;
                     fault_in = FAULT_BELOW;
                  end else begin
                     ptr_in     = ptr_ff - TAPE_AW'(1);
                     do_advance = 1'b1;
                  end
               end
               CH_OPEN: begin
                  if (cell_val != '0) begin
                     do_advance = 1'b1;
                  end else if (step_over) begin
                     halt_in  = 1'b1;
                     fault_in = FAULT_BRACKET;
                  end else begin
                     idx_in       = step_res;
                     depth_in     = PC_CNT_W'(1);
                     back_in      = 1'b0;
                     prog_rd_addr = step_res;
                     state_in     = ST_SCAN;
                  end
               end
               CH_CLOSE: begin
                  if (cell_val == '0) begin
                     do_advance = 1'b1;
                  end else if (pc_ff == '0) begin
                     halt_in  = 1'b1;
                     fault_in = FAULT_BRACKET;
                  end else begin
                     idx_in       = step_res;
                     depth_in     = PC_CNT_W'(1);
                     back_in      = 1'b1;
                     prog_rd_addr = step_res;
                     state_in     = ST_SCAN;
                  end
               end
               default: begin
                  do_advance = 1'b1;
               end
            endcase
         end

         ST_SCAN: begin
            if (scan_match) begin
               do_advance = 1'b1;
               state_in   = ST_PUBLISH;
            end else if (!back_ff && prog_rd_data == CH_END) begin
               halt_in  = 1'b1;
               fault_in = FAULT_BRACKET;
               state_in = ST_PUBLISH;
            end else begin
               if (prog_rd_data == (back_ff ? CH_CLOSE : CH_OPEN)) begin
                  depth_in = depth_ff + PC_CNT_W'(1);
               end else if (prog_rd_data == (back_ff ? CH_OPEN : CH_CLOSE)) begin
                  depth_in = depth_ff - PC_CNT_W'(1);
               end
               // Walking off either end of the store leaves the bracket unmatched.
               if (back_ff ? (idx_ff == '0) : step_over) begin
                  halt_in  = 1'b1;
                  fault_in = FAULT_BRACKET;
                  state_in = ST_PUBLISH;
               end else begin
                  idx_in       = step_res;
                  prog_rd_addr = step_res;
               end
            end
         end

         ST_PUBLISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {PCO_W'(pc_ff), ERR_W'(fault_ff), halt_ff, taken_ff,
                               emit_byte_ff};
               rsp_user_in  = emit_valid_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Moving past the last store address halts with pc left at that last address.
      if (do_advance) begin
         if (step_over) begin
            pc_in    = step_base;
            halt_in  = 1'b1;
            fault_in = FAULT_NONE;
         end else begin
            pc_in = step_res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pc_ff         <= '0;
         ptr_ff        <= '0;
         fill_ff       <= '0;
         usable_ff     <= TAPE_CNT_W'(TAPE_DEPTH);
         halt_ff       <= 1'b0;
         fault_ff      <= FAULT_NONE;
         emit_valid_ff <= 1'b0;
         taken_ff      <= 1'b0;
         back_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pc_ff         <= pc_in;
         ptr_ff        <= ptr_in;
         fill_ff       <= fill_in;
         halt_ff       <= halt_in;
         fault_ff      <= fault_in;
         emit_valid_ff <= emit_valid_in;
         taken_ff      <= taken_in;
         back_ff       <= back_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            usable_ff <= usable_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff   <= in_byte_in;
      idx_ff       <= idx_in;
      depth_ff     <= depth_in;
      emit_byte_ff <= emit_byte_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   tmi_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (PROG_DEPTH)
   ) u_prog_ram (
      .clock   (clock),
      .wr_en   (prog_we),
      .wr_addr (PC_W'(req_addr)),
      .wr_data (req_char),
      .rd_en   (1'b1),
      .rd_addr (prog_rd_addr),
      .rd_data (prog_rd_data)
   );

   tmi_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (TAPE_DEPTH)
   ) u_tape_ram (
      .clock   (clock),
      .wr_en   (tape_we),
      .wr_addr (ptr_ff),
      .wr_data (tape_wdata),
      .rd_en   (1'b1),
      .rd_addr (ptr_ff),
      .rd_data (tape_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `ASSERT_AT(a_ptr_within_fill, clock, reset, ptr_ext <= fill_ff)
   `ASSERT_NEXT(a_rsp_held, clock, reset, rsp_stall, rsp_valid_ff && $stable(rsp_data_ff))
   `ASSERT_IMPL(a_fault_halts, clock, reset, fault_ff != FAULT_NONE, halt_ff)
   `ASSERT_NEXT(a_exec_fetches, clock, reset, exec_go, state_ff == ST_FETCH)

endmodule

`default_nettype wire

[design/tmi_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tmi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic                                       rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
